// ===== hw/rtl/sobt_pkg.sv =====
`timescale 1ns / 1ps

package sobt_pkg;

    // Frame geometry
    localparam int ImageSize = 256;
    localparam int ColW      = $clog2(ImageSize);
    localparam int RowW      = $clog2(ImageSize + 2);
    localparam int RowFlush  = ImageSize;
    localparam int RowEnd    = ImageSize + 1;

    // Datapath widths
    localparam int PixW  = 8;
    localparam int ThrW  = 11;
    localparam int SumW  = 10;
    localparam int GradW = 11;
    localparam int SqW   = 2 * SumW;
    localparam int MagW  = SqW + 1;
    localparam int TsqW  = 2 * ThrW;
    localparam int LimW  = TsqW + 1;

    localparam logic [ThrW-1:0] ThrReset  = ThrW'(180);
    localparam logic [PixW-1:0] PixBlack  = '0;
    localparam logic [PixW-1:0] PixWhite  = '1;

    // Item kinds
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [PixW-1:0]  pixel;
    } t_in_beat;

    typedef struct packed {
        logic [PixW-1:0]  edge_pixel;
        logic             last_of_frame;
    } t_out_beat;

    // One line store entry: the two rows above the incoming one
    typedef struct packed {
        logic [PixW-1:0]  upper;
        logic [PixW-1:0]  middle;
    } t_line_pair;

    typedef logic [2:0][2:0][PixW-1:0] t_taps;

    // Window handed to the gradient datapath, with border masks
    typedef struct packed {
        t_taps  taps;
        logic   top_out;
        logic   bot_out;
        logic   left_out;
        logic   right_out;
        logic   last;
    } t_win_beat;

endpackage

// ===== hw/rtl/sobt_line_store.sv =====
`timescale 1ns / 1ps

module sobt_line_store (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [sobt_pkg::ColW-1:0]      i_rd_addr,
    output sobt_pkg::t_line_pair           o_rd_data,
    input  logic                           i_wr_en,
    input  logic [sobt_pkg::ColW-1:0]      i_wr_addr,
    input  sobt_pkg::t_line_pair           i_wr_data
);
    import sobt_pkg::*;

    t_line_pair r_mem [ImageSize];
    t_line_pair r_rd_data;

    // Write the shifted column back
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/sobt_window.sv =====
`timescale 1ns / 1ps

module sobt_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  sobt_pkg::t_in_beat         i_data,
    output logic                       o_rd_en,
    output logic [sobt_pkg::ColW-1:0]  o_rd_addr,
    input  sobt_pkg::t_line_pair       i_rd_data,
    output logic                       o_wr_en,
    output logic [sobt_pkg::ColW-1:0]  o_wr_addr,
    output sobt_pkg::t_line_pair       o_wr_data,
    output logic                       o_valid,
    output sobt_pkg::t_win_beat        o_beat,
    input  logic                       i_stall
);
    import sobt_pkg::*;

    // Stream position of the next item
    logic [ColW-1:0] r_col, n_col;
    logic [RowW-1:0] r_row, n_row;

    // Stage 1: line store read in flight
    logic            r_v1;
    logic [ColW-1:0] r1_col;
    logic [PixW-1:0] r1_inc;
    logic            r1_produce, r1_top, r1_bot, r1_left, r1_right, r1_last;

    // Stage 2: window and masks
    logic            r_v2;
    t_taps           r_win;
    logic            r2_top, r2_bot, r2_left, r2_right, r2_last;

    logic            accept, s1_adv, s2_ready;
    logic            col_zero;
    logic [PixW-1:0] incoming;

    assign s2_ready = !r_v2 || !i_stall;
    assign s1_adv   = r_v1 && s2_ready;
    assign o_stall  = r_v1 && !s2_ready;
    assign accept   = i_valid && !o_stall;

    // Flush in a pixel slot reads as zero; pixels past the frame are ignored
    assign incoming = (i_data.kind == KIND_PIXEL && r_row < RowW'(ImageSize))
                      ? i_data.pixel : '0;
    assign col_zero = (r_col == '0);

    // Advance position, wrap after the final flush beat
    always_comb begin
        if (r_row == RowW'(RowEnd)) begin
            n_col = '0;
            n_row = '0;
        end else if (r_col == ColW'(ImageSize - 1)) begin
            n_col = '0;
            n_row = r_row + RowW'(1);
        end else begin
            n_col = r_col + ColW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (s1_adv) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_col     <= r_col;
            r1_inc     <= incoming;
            r1_produce <= (!col_zero && r_row != '0) || (col_zero && r_row >= RowW'(2));
            r1_top     <= col_zero ? (r_row == RowW'(2)) : (r_row == RowW'(1));
            r1_bot     <= col_zero ? (r_row == RowW'(RowEnd)) : (r_row == RowW'(RowFlush));
            r1_left    <= (r_col == ColW'(1));
            r1_right   <= col_zero;
            r1_last    <= col_zero && (r_row == RowW'(RowEnd));
        end
    end

    // Read at accept, write back the rotated column as stage 1 leaves
    assign o_rd_en          = accept;
    assign o_rd_addr        = r_col;
    assign o_wr_en          = s1_adv;
    assign o_wr_addr        = r1_col;
    assign o_wr_data.upper  = i_rd_data.middle;
    assign o_wr_data.middle = r1_inc;

    // Shift window and load the new column; drop beats without a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_win <= '0;
        end else if (s1_adv) begin
            r_v2 <= r1_produce;
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_rd_data.upper;
            r_win[1][2] <= i_rd_data.middle;
            r_win[2][2] <= r1_inc;
        end else if (s2_ready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r2_top   <= r1_top;
            r2_bot   <= r1_bot;
            r2_left  <= r1_left;
            r2_right <= r1_right;
            r2_last  <= r1_last;
        end
    end

    assign o_valid          = r_v2;
    assign o_beat.taps      = r_win;
    assign o_beat.top_out   = r2_top;
    assign o_beat.bot_out   = r2_bot;
    assign o_beat.left_out  = r2_left;
    assign o_beat.right_out = r2_right;
    assign o_beat.last      = r2_last;

    // Read and write of one cycle never meet at the same column, except at the
    // frame wrap, where the stale read only lands in taps that are masked
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s1_adv && !(r_row == '0 && r_col == '0)) |-> (r_col != r1_col))
        else $error("line store read and write collide");

    // Position wraps to zero after the final flush beat
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_row == RowW'(RowEnd)) |=> (r_row == '0 && r_col == '0))
        else $error("position did not wrap at end of frame");

endmodule

// ===== hw/rtl/sobt_grad.sv =====
`timescale 1ns / 1ps

module sobt_grad (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  sobt_pkg::t_win_beat         i_beat,
    input  logic [sobt_pkg::ThrW-1:0]   i_threshold,
    output logic                        o_valid,
    output sobt_pkg::t_out_beat         o_data,
    input  logic                        i_stall
);
    import sobt_pkg::*;

    logic            r_v3, r_v4, r_vo;
    logic [SumW-1:0] r_ax, r_ay;
    logic [SqW-1:0]  r_sqx, r_sqy;
    logic            r3_last, r4_last;
    t_out_beat       r_out;
    logic [TsqW-1:0] r_tsq;
    logic [LimW-1:0] r_lim;

    logic            out_ready, s4_ready, s3_ready;
    t_taps           m;
    logic [SumW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [GradW-1:0] gx, gy;
    logic [SumW-1:0] ax, ay;
    logic [MagW-1:0] mag2;

    assign out_ready = !r_vo || !i_stall;
    assign s4_ready  = !r_v4 || out_ready;
    assign s3_ready  = !r_v3 || s4_ready;
    assign o_stall   = !s3_ready;

    // Zero the taps that fall outside the frame
    always_comb begin
        m = i_beat.taps;
        for (int c = 0; c < 3; c++) begin
            if (i_beat.top_out) m[0][c] = '0;
            if (i_beat.bot_out) m[2][c] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            if (i_beat.left_out)  m[r][0] = '0;
            if (i_beat.right_out) m[r][2] = '0;
        end
    end

    // Horizontal and vertical kernel sums and their magnitudes
    always_comb begin
        gx_pos = SumW'(m[0][2]) + SumW'({m[1][2], 1'b0}) + SumW'(m[2][2]);
        gx_neg = SumW'(m[0][0]) + SumW'({m[1][0], 1'b0}) + SumW'(m[2][0]);
        gy_pos = SumW'(m[2][0]) + SumW'({m[2][1], 1'b0}) + SumW'(m[2][2]);
        gy_neg = SumW'(m[0][0]) + SumW'({m[0][1], 1'b0}) + SumW'(m[0][2]);
        gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
        gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
        ax     = gx[GradW-1] ? SumW'(-gx) : gx[SumW-1:0];
        ay     = gy[GradW-1] ? SumW'(-gy) : gy[SumW-1:0];
    end

    // Stage 3: absolute gradients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_ready) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && i_valid) begin
            r_ax    <= ax;
            r_ay    <= ay;
            r3_last <= i_beat.last;
        end
    end

    // Stage 4: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (s4_ready) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_ready && r_v3) begin
            r_sqx   <= SqW'(r_ax) * SqW'(r_ax);
            r_sqy   <= SqW'(r_ay) * SqW'(r_ay);
            r4_last <= r3_last;
        end
    end

    // Threshold limit T*T+T+1, settled well before any beat reaches it
    always_ff @(posedge i_clk) begin
        r_tsq <= TsqW'(i_threshold) * TsqW'(i_threshold);
        r_lim <= {1'b0, r_tsq} + LimW'(i_threshold) + LimW'(1);
    end

    assign mag2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Output register: compare and hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (out_ready) begin
            r_vo <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_v4) begin
            r_out.edge_pixel    <= (LimW'(mag2) >= r_lim) ? PixBlack : PixWhite;
            r_out.last_of_frame <= r4_last;
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_out;

    // Limit matches a threshold that has stayed stable while it passed r_tsq and r_lim
    a_lim_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($stable(i_threshold) && $past($stable(i_threshold)))
        |-> (r_lim == LimW'(TsqW'(i_threshold) * TsqW'(i_threshold))
                      + LimW'(i_threshold) + LimW'(1)))
        else $error("threshold limit out of step");

    // A result is only black or white
    a_out_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.edge_pixel == PixBlack || o_data.edge_pixel == PixWhite))
        else $error("edge pixel neither black nor white");

endmodule

// ===== hw/rtl/sobel_edge_threshold.sv =====
`timescale 1ns / 1ps

// 3x3 Sobel edge detector with threshold. Grey pixels of a square frame
// (ImageSize x ImageSize) enter in raster order, followed by ImageSize+1 flush
// beats that drain the frame; each result lags its pixel by one row plus one
// beat, and the result for the bottom-right pixel carries last_of_frame. A
// pixel is an edge (0) when gx*gx+gy*gy >= T*T+T+1, else 255; neighbors outside
// the frame count as zero. One beat is accepted every clock unless the input
// is stalled: the two line stores share one memory, read at accept and written
// back as the beat leaves the read stage; the window takes two stages and the
// gradient path three, so a beat's result passes both window stages, both
// gradient stages and the output register, and waits there while the output is
// stalled. The threshold may only be written while no beat is in flight.

module sobel_edge_threshold (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sobt_pkg::ThrW-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  sobt_pkg::t_in_beat         i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output sobt_pkg::t_out_beat        o_data
);
    import sobt_pkg::*;

    logic [ThrW-1:0] r_threshold;

    logic            rd_en, wr_en;
    logic [ColW-1:0] rd_addr, wr_addr;
    t_line_pair      rd_data, wr_data;

    logic            win_valid, grad_stall;
    t_win_beat       win_beat;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThrReset;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    sobt_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    sobt_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_valid   (win_valid),
        .o_beat    (win_beat),
        .i_stall   (grad_stall)
    );

    sobt_grad u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .o_stall     (grad_stall),
        .i_beat      (win_beat),
        .i_threshold (r_threshold),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

// ===== verif/sobel_edge_threshold_tb.sv =====
`timescale 1ns / 1ps

module sobel_edge_threshold_tb;

    import sobt_pkg::*;

    // directed rows plus random beats, a few rows into the frame
    localparam int StreamBeats  = 2000;
    localparam int PhaseBeats   = 120;
    localparam int SettleCycles = 16;
    localparam int HoldCycles   = 600;
    localparam int CycleLimit   = 2_000_000;
    localparam int ReportMax    = 10;

    // Directed rows: a run of identical beats, with a typed result where it is obvious
    typedef struct packed {
        t_kind            kind;
        logic [PixW-1:0]  pixel;
        logic [8:0]       count;
        logic             fixed;
        t_out_beat        fixed_res;
    } t_script_row;

    localparam t_script_row Script [17] = '{
        // top row all dark
        '{KIND_PIXEL, 8'h00, 9'd256, 1'b0, '{PixWhite, 1'b0}},
        // second row dark too: top row has no gradient, so white at reset threshold
        '{KIND_PIXEL, 8'h00, 9'd256, 1'b1, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'hFF, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        // flush inside the frame stands for a zero pixel
        '{KIND_FLUSH, 8'hA5, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h00, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'hFF, 9'd2,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h01, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h80, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h7F, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'hFE, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_FLUSH, 8'h00, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h55, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'hAA, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        '{KIND_FLUSH, 8'hFF, 9'd1,   1'b0, '{PixWhite, 1'b0}},
        // finish the third row bright, then a dark row for strong horizontal edges
        '{KIND_PIXEL, 8'hFF, 9'd243, 1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'h00, 9'd256, 1'b0, '{PixWhite, 1'b0}},
        '{KIND_PIXEL, 8'hFF, 9'd40,  1'b0, '{PixWhite, 1'b0}}
    };

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [ThrW-1:0]      i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_beat             i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_beat            o_data;

    // Predictor state: line stores, window, scan position, threshold
    logic [PixW-1:0]      upper_line [ImageSize];
    logic [PixW-1:0]      middle_line [ImageSize];
    logic [PixW-1:0]      nbhd [3][3];
    int                   scan_col;
    int                   scan_row;
    int                   thr_model;

    t_out_beat            pending_edges [$];
    int                   send_idle_pct   = 0;
    int                   recv_stall_pct  = 0;
    int                   hold_requests   = 0;
    int                   hold_granted    = 0;
    int                   hold_left       = 0;
    int                   scene_level     = 128;
    int                   cycle_count     = 0;
    int                   mismatch_count  = 0;
    int                   results_seen    = 0;
    int                   frame_ends      = 0;
    int                   beats_in        = 0;
    int                   thr_settings    = 0;

    sobel_edge_threshold i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clear the predictor to its post-reset state
    function automatic void sobel_state_clear();
        for (int i = 0; i < ImageSize; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                nbhd[r][c] = '0;
            end
        end
        scan_col  = 0;
        scan_row  = 0;
        thr_model = int'(ThrReset);
    endfunction

    // Advance the window by one beat; return 1 with the edge decision when one is due
    function automatic bit sobel_edge_predict(input t_in_beat beat, output t_out_beat res);
        int              col;
        int              row;
        int              ocol;
        int              orow;
        int              gx;
        int              gy;
        int              mag2;
        int              lim;
        int              t [3][3];
        logic [PixW-1:0] incoming;
        bit              top_o;
        bit              bot_o;
        bit              left_o;
        bit              right_o;
        bit              due;

        col = scan_col;
        row = scan_row;
        res = '0;
        // flush beats and anything past the last frame row feed zero
        incoming = (beat.kind == KIND_PIXEL && row < ImageSize) ? beat.pixel : '0;
        if (col >= ImageSize) col = 0;

        for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2]       = upper_line[col];
        nbhd[1][2]       = middle_line[col];
        nbhd[2][2]       = incoming;
        upper_line[col]  = middle_line[col];
        middle_line[col] = incoming;

        due = (col >= 1 && row >= 1) || (col == 0 && row >= 2);
        if (due) begin
            if (col >= 1) begin
                ocol = col - 1;
                orow = row - 1;
            end else begin
                ocol = ImageSize - 1;
                orow = row - 2;
            end
            top_o   = (orow == 0);
            bot_o   = (orow == ImageSize - 1);
            left_o  = (ocol == 0);
            right_o = (ocol == ImageSize - 1);
            // zero the taps that fall outside the frame
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if ((r == 0 && top_o) || (r == 2 && bot_o) ||
                        (c == 0 && left_o) || (c == 2 && right_o))
                        t[r][c] = 0;
                    else
                        t[r][c] = int'(nbhd[r][c]);
                end
            end
            gx = (t[0][2] + 2 * t[1][2] + t[2][2]) - (t[0][0] + 2 * t[1][0] + t[2][0]);
            gy = (t[2][0] + 2 * t[2][1] + t[2][2]) - (t[0][0] + 2 * t[0][1] + t[0][2]);
            mag2 = gx * gx + gy * gy;
            lim  = thr_model * thr_model + thr_model + 1;
            res.edge_pixel    = (mag2 >= lim) ? PixBlack : PixWhite;
            res.last_of_frame = (orow == ImageSize - 1 && ocol == ImageSize - 1);
        end

        // wrap after the final flush beat
        if (row >= ImageSize + 1) begin
            scan_col = 0;
            scan_row = 0;
        end else if (col + 1 >= ImageSize) begin
            scan_col = 0;
            scan_row = row + 1;
        end else begin
            scan_col = col + 1;
            scan_row = row;
        end
        return due;
    endfunction

    // Blocky scene with noise inside the frame, mostly flush beats after it
    function automatic t_in_beat scene_beat();
        t_in_beat b;
        int       v;

        if (scan_row < ImageSize) begin
            if ($urandom_range(0, 39) == 0) scene_level = $urandom_range(0, 255);
            b.kind = ($urandom_range(0, 49) == 0) ? KIND_FLUSH : KIND_PIXEL;
            if ($urandom_range(0, 3) == 0) begin
                b.pixel = PixW'($urandom_range(0, 255));
            end else begin
                v = scene_level + int'($urandom_range(0, 16)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                b.pixel = PixW'(v);
            end
        end else begin
            b.kind  = ($urandom_range(0, 9) == 0) ? KIND_PIXEL : KIND_FLUSH;
            b.pixel = PixW'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= ReportMax)
            $display("Mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
    endfunction

    // Offer one beat after a random gap; predict it once it is taken
    task automatic offer_beat(input t_in_beat beat, input bit use_fixed,
                              input t_out_beat fixed_res);
        t_out_beat res;
        bit        due;

        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        due = sobel_edge_predict(beat, res);
        if (due) pending_edges.push_back(use_fixed ? fixed_res : res);
        beats_in++;
    endtask

    // Hold the input until every expected beat is out and the pipeline is empty
    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic load_threshold(input int value);
        i_cfg_data <= ThrW'(value);
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_model  = value;
        thr_settings++;
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin : recv_side
        if (hold_granted != hold_requests) begin
            hold_granted <= hold_requests;
            hold_left    <= HoldCycles;
            i_stall      <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_edges.size() == 0) begin
                note_mismatch("unexpected result, edge_pixel", -1, int'(o_data.edge_pixel));
            end else begin
                want = pending_edges.pop_front();
                results_seen++;
                if (o_data.edge_pixel !== want.edge_pixel)
                    note_mismatch("edge_pixel", int'(want.edge_pixel),
                                  int'(o_data.edge_pixel));
                if (o_data.last_of_frame !== want.last_of_frame)
                    note_mismatch("last_of_frame", int'(want.last_of_frame),
                                  int'(o_data.last_of_frame));
                if (want.last_of_frame) frame_ends++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_edges.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_beat beat;
        int       thr;
        int       phase;

        sobel_state_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset threshold
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        for (int r = 0; r < $size(Script); r++) begin
            for (int k = 0; k < int'(Script[r].count); k++) begin
                beat.kind  = Script[r].kind;
                beat.pixel = Script[r].pixel;
                offer_beat(beat, Script[r].fixed, Script[r].fixed_res);
            end
        end
        drain_all();

        // Random phases through the following rows, threshold per phase
        phase = 0;
        while (beats_in < StreamBeats) begin
            case (phase % 8)
                0: thr = 0;
                1: thr = 1443;
                2: thr = $urandom_range(0, 1443);
                3: thr = 1442;
                4: thr = $urandom_range(0, 300);
                5: thr = int'(ThrReset);
                6: thr = 1;
                default: thr = $urandom_range(30, 700);
            endcase
            load_threshold(thr);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (phase % 11 == 2) begin
                send_idle_pct = 0;
                hold_requests++;
            end

            for (int k = 0; k < PhaseBeats && beats_in < StreamBeats; k++)
                offer_beat(scene_beat(), 1'b0, '0);
            drain_all();
            phase++;
        end

        if (pending_edges.size() != 0) begin
            $display("%0d expected results never arrived", pending_edges.size());
            mismatch_count++;
        end
        $display("Run covered %0d beats, %0d threshold settings, %0d results compared",
                 beats_in, thr_settings, results_seen);
        $display("Frame ends seen %0d, long hold-offs %0d, mismatches %0d, cycles %0d",
                 frame_ends, hold_requests, mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sobt_pkg.sv
hw/rtl/sobt_line_store.sv
hw/rtl/sobt_window.sv
hw/rtl/sobt_grad.sv
hw/rtl/sobel_edge_threshold.sv
verif/sobel_edge_threshold_tb.sv
